@@ rtl/qmix_pkg.sv @@
`timescale 1ns / 1ps

package qmix_pkg;

  localparam int ONE_Q12          = 4096;
  localparam int BISECT_STEPS_DEF = 12;
  // quotient bits of the roll/pitch rescale; the quotient never exceeds 2048
  localparam int DIV_BITS         = 12;
  localparam int CMD_W            = 16;
  localparam int CODE_W           = 11;
  localparam int IDLE_W           = 13;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THR = 2'd2;

  localparam logic [CODE_W-1:0] CODE_MIN_RST = 11'd48;
  localparam logic [CODE_W-1:0] CODE_MAX_RST = 11'd2047;
  localparam logic [IDLE_W-1:0] IDLE_THR_RST = 13'd205;

  // side info that rides along with every transaction
  typedef struct packed {
    logic                    idle;
    logic                    sat;
    logic [12:0]             req;
    logic signed [CMD_W-1:0] yaw;
  } mix_ctl_t;

endpackage

@@ rtl/qmix_if.sv @@
`timescale 1ns / 1ps

interface qmix_in_if;
  logic        valid;
  logic        ready;
  logic        armed;
  logic signed [15:0] throttle;
  logic signed [15:0] roll_cmd;
  logic signed [15:0] pitch_cmd;
  logic signed [15:0] yaw_cmd;

  modport source(output valid, armed, throttle, roll_cmd, pitch_cmd, yaw_cmd, input ready);
  modport sink(input valid, armed, throttle, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

interface qmix_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] front_left_code;
  logic [10:0] front_right_code;
  logic [10:0] back_right_code;
  logic [10:0] back_left_code;
  logic        saturated;
  logic        idle;

  modport source(output valid, front_left_code, front_right_code, back_right_code,
                 back_left_code, saturated, idle, input ready);
  modport sink(input valid, front_left_code, front_right_code, back_right_code,
               back_left_code, saturated, idle, output ready);
endinterface

@@ rtl/quad_x_motor_mixer_desaturate.sv @@
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output is not stalled; the rescale divider, the bisection
// (two stages per step) and the code mapping are all fully pipelined.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.

module quad_x_motor_mixer_desaturate #(
  parameter int BISECT_STEPS = qmix_pkg::BISECT_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  qmix_in_if.sink                             in_ch,
  qmix_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [qmix_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [qmix_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int S  = BISECT_STEPS;
  localparam int PW = S + 18;
  localparam int DB = qmix_pkg::DIV_BITS;
  localparam logic [S:0] LOW_THR = (S+1)'((999 * (2 ** S) + 999) / 1000);

  // ---------------- configuration ----------------
  logic [10:0] code_min_r, code_max_r;
  logic [12:0] idle_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_min_r <= qmix_pkg::CODE_MIN_RST;
      code_max_r <= qmix_pkg::CODE_MAX_RST;
      idle_thr_r <= qmix_pkg::IDLE_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        qmix_pkg::CFG_CODE_MIN: code_min_r <= cfg_wdata[10:0];
        qmix_pkg::CFG_CODE_MAX: code_max_r <= cfg_wdata[10:0];
        qmix_pkg::CFG_IDLE_THR: idle_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic out_v_r;
  logic adv;
  assign adv = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- helpers ----------------
  function automatic logic signed [17:0] rnd_term(input logic signed [PW-1:0] x);
    logic [PW-1:0] mag;
    logic [PW-1:0] q;
    mag = x[PW-1] ? PW'(-x) : PW'(x);
    q = (mag + (PW'(1) << (S - 1))) >> S;
    rnd_term = x[PW-1] ? -$signed(q[17:0]) : $signed(q[17:0]);
  endfunction

  function automatic logic signed [18:0] max2(input logic signed [18:0] x,
                                              input logic signed [18:0] y);
    max2 = (x > y) ? x : y;
  endfunction

  function automatic logic signed [18:0] min2(input logic signed [18:0] x,
                                              input logic signed [18:0] y);
    min2 = (x < y) ? x : y;
  endfunction

  // corrections of the four motors: FL, FR, BR, BL
  function automatic logic signed [18:0] corr_of(input logic [1:0] m,
                                                 input logic signed [12:0] a,
                                                 input logic signed [12:0] b,
                                                 input logic signed [17:0] t);
    logic signed [18:0] ae, be, te;
    ae = 19'(a);
    be = 19'(b);
    te = 19'(t);
    unique case (m)
      2'd0:    corr_of = ae - te;
      2'd1:    corr_of = be + te;
      2'd2:    corr_of = -ae - te;
      default: corr_of = -be + te;
    endcase
  endfunction

  function automatic logic span_ok(input logic signed [12:0] a,
                                   input logic signed [12:0] b,
                                   input logic signed [17:0] t);
    logic signed [18:0] c0, c1, c2, c3, mx, mn;
    logic signed [19:0] sp;
    c0 = corr_of(2'd0, a, b, t);
    c1 = corr_of(2'd1, a, b, t);
    c2 = corr_of(2'd2, a, b, t);
    c3 = corr_of(2'd3, a, b, t);
    mx = max2(max2(c0, c1), max2(c2, c3));
    mn = min2(min2(c0, c1), min2(c2, c3));
    sp = 20'(mx) - 20'(mn);
    span_ok = (sp <= 20'sd4096);
  endfunction

  // ---------------- stage 0: clamp, idle test, roll/pitch diffs ----------------
  logic                 v0_r;
  qmix_pkg::mix_ctl_t   c0_r, c0_nxt;
  logic signed [17:0]   a0_r, b0_r, a0_nxt, b0_nxt;
  logic                 thr_lo, thr_hi;

  always_comb begin
    thr_lo = in_ch.throttle < 16'sd0;
    thr_hi = in_ch.throttle > 16'sd4096;
    c0_nxt.req  = thr_lo ? 13'd0 : (thr_hi ? 13'd4096 : in_ch.throttle[12:0]);
    c0_nxt.sat  = thr_lo || thr_hi;
    c0_nxt.idle = !in_ch.armed || (c0_nxt.req <= idle_thr_r);
    c0_nxt.yaw  = in_ch.yaw_cmd;
    a0_nxt = 18'(in_ch.roll_cmd) - 18'(in_ch.pitch_cmd);
    b0_nxt = -18'(in_ch.roll_cmd) - 18'(in_ch.pitch_cmd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) begin
      v0_r <= in_ch.valid;
      c0_r <= c0_nxt;
      a0_r <= a0_nxt;
      b0_r <= b0_nxt;
    end
  end

  // ---------------- stage 1: span and divider setup ----------------
  logic                 dv_v_r    [0:DB];
  qmix_pkg::mix_ctl_t   dv_c_r    [0:DB];
  logic                 dv_need_r [0:DB];
  logic                 dv_sa_r   [0:DB];
  logic                 dv_sb_r   [0:DB];
  logic signed [12:0]   dv_a_r    [0:DB];
  logic signed [12:0]   dv_b_r    [0:DB];
  logic [18:0]          dv_d_r    [0:DB];
  logic [30:0]          dv_ra_r   [0:DB];
  logic [30:0]          dv_rb_r   [0:DB];
  logic [DB-1:0]        dv_qa_r   [0:DB];
  logic [DB-1:0]        dv_qb_r   [0:DB];

  logic [16:0] ma, mb, mab;
  logic [17:0] span1;

  always_comb begin
    ma    = a0_r[17] ? 17'(-a0_r) : 17'(a0_r);
    mb    = b0_r[17] ? 17'(-b0_r) : 17'(b0_r);
    mab   = (ma > mb) ? ma : mb;
    span1 = {mab, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) begin
      dv_v_r[0]    <= v0_r;
      dv_c_r[0]    <= c0_r;
      dv_need_r[0] <= span1 > 18'd4096;
      dv_sa_r[0]   <= a0_r[17];
      dv_sb_r[0]   <= b0_r[17];
      dv_a_r[0]    <= a0_r[12:0];
      dv_b_r[0]    <= b0_r[12:0];
      // round(|x| * 4096 / span) = floor((|x| * 8192 + span) / (2 * span))
      dv_d_r[0]    <= {span1, 1'b0};
      dv_ra_r[0]   <= {1'b0, ma, 13'd0} + 31'(span1);
      dv_rb_r[0]   <= {1'b0, mb, 13'd0} + 31'(span1);
      dv_qa_r[0]   <= '0;
      dv_qb_r[0]   <= '0;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar j = 0; j < DB; j++) begin : g_div
    logic [30:0] trial;
    logic        ge_a, ge_b;
    assign trial = 31'(dv_d_r[j]) << (DB - 1 - j);
    assign ge_a  = dv_ra_r[j] >= trial;
    assign ge_b  = dv_rb_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else if (adv) begin
        dv_v_r[j+1]    <= dv_v_r[j];
        dv_c_r[j+1]    <= dv_c_r[j];
        dv_need_r[j+1] <= dv_need_r[j];
        dv_sa_r[j+1]   <= dv_sa_r[j];
        dv_sb_r[j+1]   <= dv_sb_r[j];
        dv_a_r[j+1]    <= dv_a_r[j];
        dv_b_r[j+1]    <= dv_b_r[j];
        dv_d_r[j+1]    <= dv_d_r[j];
        dv_ra_r[j+1]   <= ge_a ? dv_ra_r[j] - trial : dv_ra_r[j];
        dv_rb_r[j+1]   <= ge_b ? dv_rb_r[j] - trial : dv_rb_r[j];
        dv_qa_r[j+1]   <= dv_qa_r[j] | (ge_a ? (DB'(1) << (DB - 1 - j)) : '0);
        dv_qb_r[j+1]   <= dv_qb_r[j] | (ge_b ? (DB'(1) << (DB - 1 - j)) : '0);
      end
    end
  end

  // ---------------- bisection entry: pick scaled or raw roll/pitch ----------------
  logic                 bs_v_r   [0:S];
  qmix_pkg::mix_ctl_t   bs_c_r   [0:S];
  logic signed [12:0]   bs_a_r   [0:S];
  logic signed [12:0]   bs_b_r   [0:S];
  logic [S-1:0]         bs_low_r [0:S];
  logic signed [PW-1:0] bs_p_r   [0:S];

  logic signed [12:0] qa13, qb13, sa_nxt, sb_nxt;
  qmix_pkg::mix_ctl_t sc_c_nxt;

  always_comb begin
    qa13   = $signed(13'(dv_qa_r[DB]));
    qb13   = $signed(13'(dv_qb_r[DB]));
    sa_nxt = dv_need_r[DB] ? (dv_sa_r[DB] ? -qa13 : qa13) : dv_a_r[DB];
    sb_nxt = dv_need_r[DB] ? (dv_sb_r[DB] ? -qb13 : qb13) : dv_b_r[DB];
    sc_c_nxt     = dv_c_r[DB];
    sc_c_nxt.sat = dv_c_r[DB].sat || dv_need_r[DB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) bs_v_r[0] <= 1'b0;
    else if (adv) begin
      bs_v_r[0]   <= dv_v_r[DB];
      bs_c_r[0]   <= sc_c_nxt;
      bs_a_r[0]   <= sa_nxt;
      bs_b_r[0]   <= sb_nxt;
      bs_low_r[0] <= '0;
      bs_p_r[0]   <= '0;
    end
  end

  // ---------------- bisection: term stage, then span test stage ----------------
  // bs_p_r holds yaw * low exactly, so yaw * mid is one add of a shifted yaw.
  logic                 ba_v_r   [0:S-1];
  qmix_pkg::mix_ctl_t   ba_c_r   [0:S-1];
  logic signed [12:0]   ba_a_r   [0:S-1];
  logic signed [12:0]   ba_b_r   [0:S-1];
  logic [S-1:0]         ba_low_r [0:S-1];
  logic signed [PW-1:0] ba_p_r   [0:S-1];
  logic signed [PW-1:0] ba_pm_r  [0:S-1];
  logic signed [17:0]   ba_t_r   [0:S-1];

  for (genvar k = 0; k < S; k++) begin : g_bis
    logic signed [PW-1:0] pm_nxt;
    logic                 ok;
    assign pm_nxt = bs_p_r[k] + (PW'(bs_c_r[k].yaw) <<< (S - 1 - k));
    assign ok     = span_ok(ba_a_r[k], ba_b_r[k], ba_t_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) ba_v_r[k] <= 1'b0;
      else if (adv) begin
        ba_v_r[k]   <= bs_v_r[k];
        ba_c_r[k]   <= bs_c_r[k];
        ba_a_r[k]   <= bs_a_r[k];
        ba_b_r[k]   <= bs_b_r[k];
        ba_low_r[k] <= bs_low_r[k];
        ba_p_r[k]   <= bs_p_r[k];
        ba_pm_r[k]  <= pm_nxt;
        ba_t_r[k]   <= rnd_term(pm_nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) bs_v_r[k+1] <= 1'b0;
      else if (adv) begin
        bs_v_r[k+1]   <= ba_v_r[k];
        bs_c_r[k+1]   <= ba_c_r[k];
        bs_a_r[k+1]   <= ba_a_r[k];
        bs_b_r[k+1]   <= ba_b_r[k];
        bs_low_r[k+1] <= ok ? (ba_low_r[k] | (S'(1) << (S - 1 - k))) : ba_low_r[k];
        bs_p_r[k+1]   <= ok ? ba_pm_r[k] : ba_p_r[k];
      end
    end
  end

  // ---------------- F1: final corrections ----------------
  logic               f1_v_r;
  qmix_pkg::mix_ctl_t f1_c_r, f1_c_nxt;
  logic signed [18:0] f1_corr_r [0:3];
  logic signed [17:0] tf;

  always_comb begin
    tf = rnd_term(bs_p_r[S]);
    f1_c_nxt     = bs_c_r[S];
    f1_c_nxt.sat = bs_c_r[S].sat || ({1'b0, bs_low_r[S]} < LOW_THR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f1_v_r <= 1'b0;
    else if (adv) begin
      f1_v_r <= bs_v_r[S];
      f1_c_r <= f1_c_nxt;
      for (int m = 0; m < 4; m++) begin
        f1_corr_r[m] <= corr_of(2'(m), bs_a_r[S], bs_b_r[S], tf);
      end
    end
  end

  // ---------------- F2: min and max of corrections ----------------
  logic               f2_v_r;
  qmix_pkg::mix_ctl_t f2_c_r;
  logic signed [18:0] f2_corr_r [0:3];
  logic signed [18:0] f2_mn_r, f2_mx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f2_v_r <= 1'b0;
    else if (adv) begin
      f2_v_r    <= f1_v_r;
      f2_c_r    <= f1_c_r;
      f2_corr_r <= f1_corr_r;
      f2_mn_r   <= min2(min2(f1_corr_r[0], f1_corr_r[1]), min2(f1_corr_r[2], f1_corr_r[3]));
      f2_mx_r   <= max2(max2(f1_corr_r[0], f1_corr_r[1]), max2(f1_corr_r[2], f1_corr_r[3]));
    end
  end

  // ---------------- F3: throttle shift ----------------
  logic               f3_v_r;
  qmix_pkg::mix_ctl_t f3_c_r, f3_c_nxt;
  logic signed [18:0] f3_corr_r [0:3];
  logic signed [19:0] f3_adj_r, adj_nxt, lo_t, hi_t, req_s;

  always_comb begin
    lo_t  = -20'(f2_mn_r);
    hi_t  = 20'sd4096 - 20'(f2_mx_r);
    req_s = $signed(20'(f2_c_r.req));
    priority if (req_s < lo_t) adj_nxt = lo_t;
    else if (req_s > hi_t)     adj_nxt = hi_t;
    else                       adj_nxt = req_s;
    f3_c_nxt     = f2_c_r;
    f3_c_nxt.sat = f2_c_r.sat || (adj_nxt != req_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f3_v_r <= 1'b0;
    else if (adv) begin
      f3_v_r    <= f2_v_r;
      f3_c_r    <= f3_c_nxt;
      f3_corr_r <= f2_corr_r;
      f3_adj_r  <= adj_nxt;
    end
  end

  // ---------------- F4: motor powers ----------------
  logic               f4_v_r;
  qmix_pkg::mix_ctl_t f4_c_r;
  logic [12:0]        f4_p_r [0:3];
  logic [12:0]        p_nxt  [0:3];
  logic signed [20:0] psum   [0:3];

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      psum[m] = 21'(f3_adj_r) + 21'(f3_corr_r[m]);
      if (psum[m] < 21'sd0)         p_nxt[m] = 13'd0;
      else if (psum[m] > 21'sd4096) p_nxt[m] = 13'd4096;
      else                          p_nxt[m] = psum[m][12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f4_v_r <= 1'b0;
    else if (adv) begin
      f4_v_r <= f3_v_r;
      f4_c_r <= f3_c_r;
      f4_p_r <= p_nxt;
    end
  end

  // ---------------- F5: scale by code range ----------------
  logic               f5_v_r;
  qmix_pkg::mix_ctl_t f5_c_r;
  logic signed [25:0] f5_prod_r [0:3];
  logic               f5_pz_r   [0:3];
  logic signed [11:0] code_rng;

  assign code_rng = $signed({1'b0, code_max_r}) - $signed({1'b0, code_min_r});

  always_ff @(posedge clk) begin
    if (!rst_n) f5_v_r <= 1'b0;
    else if (adv) begin
      f5_v_r <= f4_v_r;
      f5_c_r <= f4_c_r;
      for (int m = 0; m < 4; m++) begin
        f5_prod_r[m] <= 26'($signed({1'b0, f4_p_r[m]}) * code_rng);
        f5_pz_r[m]   <= (f4_p_r[m] == 13'd0);
      end
    end
  end

  // ---------------- F6: round, clamp, output register ----------------
  logic [10:0]        out_code_r [0:3];
  logic [10:0]        code_nxt   [0:3];
  logic               out_sat_r, out_idle_r;
  logic signed [26:0] vsum       [0:3];
  logic signed [26:0] vq         [0:3];
  logic signed [26:0] cmin_e, cmax_e;

  always_comb begin
    cmin_e = $signed(27'(code_min_r));
    cmax_e = $signed(27'(code_max_r));
    for (int m = 0; m < 4; m++) begin
      vsum[m] = $signed({4'd0, code_min_r, 12'd0}) + 27'(f5_prod_r[m]) + 27'sd2048;
      vq[m]   = vsum[m] >>> 12;
      priority if (f5_c_r.idle || f5_pz_r[m]) code_nxt[m] = '0;
      else if (vq[m] < cmin_e)                code_nxt[m] = code_min_r;
      else if (vq[m] > cmax_e)                code_nxt[m] = code_max_r;
      else                                    code_nxt[m] = vq[m][10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (adv) begin
      out_v_r    <= f5_v_r;
      out_code_r <= code_nxt;
      out_sat_r  <= f5_c_r.sat && !f5_c_r.idle;
      out_idle_r <= f5_c_r.idle;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.front_left_code  = out_code_r[0];
  assign out_ch.front_right_code = out_code_r[1];
  assign out_ch.back_right_code  = out_code_r[2];
  assign out_ch.back_left_code   = out_code_r[3];
  assign out_ch.saturated        = out_sat_r;
  assign out_ch.idle             = out_idle_r;

`ifndef SYNTHESIS
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.idle |-> out_ch.front_left_code == 11'd0 &&
      out_ch.front_right_code == 11'd0 && out_ch.back_right_code == 11'd0 &&
      out_ch.back_left_code == 11'd0 && !out_ch.saturated)
    else $error("idle result with nonzero code or saturation");

  a_span_fits: assert property (@(posedge clk) disable iff (!rst_n)
    f2_v_r && !f2_c_r.idle |-> (20'(f2_mx_r) - 20'(f2_mn_r)) <= 20'sd4096)
    else $error("corrections span more than full scale after bisection");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[DB] && dv_need_r[DB] |-> dv_qa_r[DB] <= DB'(2048) && dv_qb_r[DB] <= DB'(2048))
    else $error("roll/pitch rescale quotient out of range");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule
